>>> design/tufs_pkg.sv
// shared types and constants for the triangle union-find segmenter
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps

package tufs_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int VTX_W   = 12;
  localparam int COUNT_W = 13;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FINISH = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
    logic [VTX_W-1:0] vertex_c;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] segment_count;
    logic               vertex_seen;
    logic [VTX_W-1:0]   segment_id;
    logic               error_flag;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DECODE, S_T_RD, S_T_CHK, S_F_RD, S_F_CHK, S_C_RD, S_C_CHK,
    S_T_DONE, S_MCLR, S_SCAN_NEXT, S_MARK_RD, S_MARK_CHK, S_Q_RD, S_RESP
  } state_t;

  // which walk is running and where its root goes
  typedef enum logic [2:0] {
    P_A1, P_B, P_A2, P_C, P_SCAN, P_Q
  } phase_t;

  typedef enum logic [1:0] {TGT_A, TGT_B, TGT_C, TGT_SWEEP} tgt_sel_t;
  typedef enum logic {RA_CUR, RA_ROOT} rd_sel_t;
  typedef enum logic [1:0] {RSP_ERR, RSP_COUNT, RSP_UNSEEN, RSP_QUERY} rsp_t;

  typedef struct packed {
    logic     load_in;
    logic     tgt_ld;
    tgt_sel_t tgt_sel;
    logic     cur_follow;
    logic     cur_restart;
    logic     root_from_cur;
    logic     save_ra;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_new;
    logic     wr_compress;
    logic     wr_link;
    logic     seen_clr;
    logic     mark_clr;
    logic     number;
    logic     sweep_zero;
    logic     sweep_inc;
    logic     count_zero;
    logic     done_set;
    logic     done_clr;
    logic     out_ld;
    rsp_t     rsp;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic add_bad;
    logic query_bad;
    logic seen;
    logic mark;
    logic parent_is_cur;
    logic parent_is_root;
    logic sweep_end;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/tufs_ctrl.sv
// controller state machine for the segmenter: sequences find walks,
// compression, linking, clearing sweeps and numbering; uses tufs_pkg
`timescale 1ns / 1ps

module tufs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tufs_pkg::dp_stat_t stat,
  output tufs_pkg::dp_cmd_t  cmd
);
  import tufs_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  rsp_t   rsp_r, rsp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      phase_r <= P_A1;
      rsp_r   <= RSP_ERR;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      rsp_r   <= rsp_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    rsp_nxt   = rsp_r;
    unique case (state_r)
      S_CLR: if (stat.sweep_end) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (stat.op)
          OP_ADD: begin
            if (stat.add_bad) begin
              rsp_nxt   = RSP_ERR;
              state_nxt = S_RESP;
            end else begin
              phase_nxt = P_A1;
              state_nxt = S_T_RD;
            end
          end
          OP_FINISH: state_nxt = S_MCLR;
          OP_QUERY: begin
            if (stat.query_bad) begin
              rsp_nxt   = RSP_ERR;
              state_nxt = S_RESP;
            end else begin
              phase_nxt = P_Q;
              state_nxt = S_T_RD;
            end
          end
          OP_CLEAR: state_nxt = S_CLR;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_T_RD: state_nxt = S_T_CHK;
      S_T_CHK: begin
        if (stat.seen) begin
          state_nxt = S_F_RD;
        end else begin
          case (phase_r)
            P_SCAN: state_nxt = S_SCAN_NEXT;
            P_Q: begin
              rsp_nxt   = RSP_UNSEEN;
              state_nxt = S_RESP;
            end
            default: state_nxt = S_T_DONE;
          endcase
        end
      end
      S_F_RD: state_nxt = S_F_CHK;
      S_F_CHK: state_nxt = stat.parent_is_cur ? S_C_RD : S_F_RD;
      S_C_RD: state_nxt = S_C_CHK;
      S_C_CHK: state_nxt = stat.parent_is_root ? S_T_DONE : S_C_RD;
      S_T_DONE: begin
        case (phase_r)
          P_A1: begin
            phase_nxt = P_B;
            state_nxt = S_T_RD;
          end
          P_B: begin
            phase_nxt = P_A2;
            state_nxt = S_T_RD;
          end
          P_A2: begin
            phase_nxt = P_C;
            state_nxt = S_T_RD;
          end
          P_C: state_nxt = S_IDLE;
          P_SCAN: state_nxt = S_MARK_RD;
          P_Q: state_nxt = S_Q_RD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MCLR: if (stat.sweep_end) state_nxt = S_SCAN_NEXT;
      S_SCAN_NEXT: begin
        if (stat.sweep_end) begin
          rsp_nxt   = RSP_COUNT;
          state_nxt = S_RESP;
        end else begin
          phase_nxt = P_SCAN;
          state_nxt = S_T_RD;
        end
      end
      S_MARK_RD: state_nxt = S_MARK_CHK;
      S_MARK_CHK: state_nxt = S_SCAN_NEXT;
      S_Q_RD: begin
        rsp_nxt   = RSP_QUERY;
        state_nxt = S_RESP;
      end
      S_RESP: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd      = '0;
    cmd.rsp  = rsp_r;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_CLR: begin
        cmd.seen_clr  = !stat.sweep_end;
        cmd.sweep_inc = !stat.sweep_end;
      end
      S_IDLE: cmd.load_in = in_valid;
      S_DECODE: begin
        cmd.tgt_sel = TGT_A;
        cmd.tgt_ld  = 1'b1;
        if (stat.op == OP_FINISH || stat.op == OP_CLEAR) begin
          cmd.sweep_zero = 1'b1;
          cmd.count_zero = 1'b1;
        end
        if (stat.op == OP_CLEAR) cmd.done_clr = 1'b1;
      end
      S_T_RD, S_F_RD, S_C_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_CUR;
      end
      S_T_CHK: begin
        if (!stat.seen) begin
          case (phase_r)
            P_SCAN: cmd.sweep_inc = 1'b1;
            P_Q: ;
            default: begin
              cmd.wr_new        = 1'b1;
              cmd.root_from_cur = 1'b1;
            end
          endcase
        end
      end
      S_F_CHK: begin
        if (stat.parent_is_cur) begin
          cmd.root_from_cur = 1'b1;
          cmd.cur_restart   = 1'b1;
        end else begin
          cmd.cur_follow = 1'b1;
        end
      end
      S_C_CHK: begin
        if (!stat.parent_is_root) begin
          cmd.wr_compress = 1'b1;
          cmd.cur_follow  = 1'b1;
        end
      end
      S_T_DONE: begin
        case (phase_r)
          P_A1: begin
            cmd.save_ra = 1'b1;
            cmd.tgt_ld  = 1'b1;
            cmd.tgt_sel = TGT_B;
          end
          P_B: begin
            cmd.wr_link = 1'b1;
            cmd.tgt_ld  = 1'b1;
            cmd.tgt_sel = TGT_A;
          end
          P_A2: begin
            cmd.save_ra = 1'b1;
            cmd.tgt_ld  = 1'b1;
            cmd.tgt_sel = TGT_C;
          end
          P_C: begin
            cmd.wr_link  = 1'b1;
            cmd.done_clr = 1'b1;
          end
          default: ;
        endcase
      end
      S_MCLR: begin
        if (stat.sweep_end) begin
          cmd.sweep_zero = 1'b1;
        end else begin
          cmd.mark_clr  = 1'b1;
          cmd.sweep_inc = 1'b1;
        end
      end
      S_SCAN_NEXT: begin
        if (stat.sweep_end) begin
          cmd.done_set = 1'b1;
        end else begin
          cmd.tgt_ld  = 1'b1;
          cmd.tgt_sel = TGT_SWEEP;
        end
      end
      S_MARK_RD, S_Q_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_ROOT;
      end
      S_MARK_CHK: begin
        cmd.number    = !stat.mark;
        cmd.sweep_inc = 1'b1;
      end
      S_RESP: cmd.out_ld = stat.out_free;
      default: ;
    endcase
  end

endmodule

>>> design/tufs_dp.sv
// datapath for the segmenter: vertex memories, walk registers, counters
// and the result register; driven by tufs_ctrl, uses tufs_pkg
`timescale 1ns / 1ps

module tufs_dp #(
  parameter int MAX_VERTICES = tufs_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tufs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tufs_pkg::out_item_t out_item,
  input  tufs_pkg::dp_cmd_t   cmd,
  output tufs_pkg::dp_stat_t  stat
);
  import tufs_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  logic [AW-1:0]    parent_mem [MAX_VERTICES];
  logic             seen_mem   [MAX_VERTICES];
  logic             mark_mem   [MAX_VERTICES];
  logic [VTX_W-1:0] segid_mem  [MAX_VERTICES];

  logic [1:0]       op_r;
  logic [VTX_W-1:0] va_r, vb_r, vc_r;
  logic [AW-1:0]    cur_r, start_r, root_r, ra_r;
  logic [AW:0]      sweep_r;
  logic [COUNT_W-1:0] count_r;
  logic             done_r;
  logic [AW-1:0]    parent_q;
  logic             seen_q, mark_q;
  logic [VTX_W-1:0] segid_q;
  out_item_t        out_r;
  out_item_t        out_nxt;
  logic             out_valid_r;

  logic [AW+VTX_W-1:0] a_wide, b_wide, c_wide;
  logic [AW-1:0]    a_addr, b_addr, c_addr, tgt, rd_addr;
  logic             a_bad, b_bad, c_bad;

  assign a_wide = {{AW{1'b0}}, va_r};
  assign b_wide = {{AW{1'b0}}, vb_r};
  assign c_wide = {{AW{1'b0}}, vc_r};
  assign a_addr = a_wide[AW-1:0];
  assign b_addr = b_wide[AW-1:0];
  assign c_addr = c_wide[AW-1:0];
  assign a_bad  = ({20'd0, va_r} >= 32'(MAX_VERTICES));
  assign b_bad  = ({20'd0, vb_r} >= 32'(MAX_VERTICES));
  assign c_bad  = ({20'd0, vc_r} >= 32'(MAX_VERTICES));

  always_comb begin
    case (cmd.tgt_sel)
      TGT_A:   tgt = a_addr;
      TGT_B:   tgt = b_addr;
      TGT_C:   tgt = c_addr;
      default: tgt = sweep_r[AW-1:0];
    endcase
  end

  assign rd_addr = (cmd.rd_sel == RA_CUR) ? cur_r : root_r;

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.wr_new || cmd.wr_compress || cmd.wr_link) begin
      parent_mem[cmd.wr_link ? root_r : cur_r] <=
        cmd.wr_new ? cur_r : (cmd.wr_compress ? root_r : ra_r);
    end
    if (cmd.wr_new || cmd.seen_clr) begin
      seen_mem[cmd.wr_new ? cur_r : sweep_r[AW-1:0]] <= cmd.wr_new;
    end
    if (cmd.number || cmd.mark_clr) begin
      mark_mem[cmd.number ? root_r : sweep_r[AW-1:0]] <= cmd.number;
    end
    if (cmd.number) begin
      segid_mem[root_r] <= count_r[VTX_W-1:0];
    end
    if (cmd.rd_en) begin
      parent_q <= parent_mem[rd_addr];
      seen_q   <= seen_mem[rd_addr];
      mark_q   <= mark_mem[rd_addr];
      segid_q  <= segid_mem[rd_addr];
    end
  end

  // walk and item registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= in_item.operation;
      va_r <= in_item.vertex_a;
      vb_r <= in_item.vertex_b;
      vc_r <= in_item.vertex_c;
    end
    if (cmd.tgt_ld) begin
      cur_r   <= tgt;
      start_r <= tgt;
    end else if (cmd.cur_follow) begin
      cur_r <= parent_q;
    end else if (cmd.cur_restart) begin
      cur_r <= start_r;
    end
    if (cmd.root_from_cur) root_r <= cur_r;
    if (cmd.save_ra)       ra_r   <= root_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep_zero)     sweep_r <= '0;
      else if (cmd.sweep_inc) sweep_r <= sweep_r + 1'b1;
      if (cmd.count_zero)  count_r <= '0;
      else if (cmd.number) count_r <= count_r + 1'b1;
      if (cmd.done_set)      done_r <= 1'b1;
      else if (cmd.done_clr) done_r <= 1'b0;
      if (cmd.out_ld)          out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_nxt = '0;
    case (cmd.rsp)
      RSP_ERR:   out_nxt.error_flag = 1'b1;
      RSP_COUNT: out_nxt.segment_count = count_r;
      RSP_QUERY: begin
        out_nxt.vertex_seen = 1'b1;
        out_nxt.segment_id  = segid_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign stat.op             = op_t'(op_r);
  assign stat.add_bad        = a_bad || b_bad || c_bad;
  assign stat.query_bad      = a_bad || !done_r;
  assign stat.seen           = seen_q;
  assign stat.mark           = mark_q;
  assign stat.parent_is_cur  = (parent_q == cur_r);
  assign stat.parent_is_root = (parent_q == root_r);
  assign stat.sweep_end      = (sweep_r == (AW+1)'(MAX_VERTICES));
  assign stat.out_free       = !out_valid_r || !out_stall;

endmodule

>>> design/triangle_union_find_segmenter_core.sv
// Triangle mesh connected-component segmenter (union-find, path compression).
// Input channel in_valid/in_stall/in_item carries one operation per item:
// add triangle, finish (number segments), query vertex, clear.
// Result channel out_valid/out_stall/out_item: finish, query and a rejected
// add each give one item; a good add and clear give none.
// One item is in work at a time; in_stall is low only while idle.
// An add walks from a, b, a again and c to their roots, compressing each
// path, and links the roots of b and c under the root of a; an unseen
// vertex is first made seen and its own root. A query walks from a to its
// root and reads the segment id stored there. Clear sweeps the seen marks
// clear. Finish sweeps the mark memory clear, then walks from every seen
// vertex and numbers each root not yet marked, then gives the segment count.
// After reset the seen marks are swept clear, during which in_stall stays
// high. A stalled result holds in the output register, and the next result
// waits until that register is free.
// Uses tufs_pkg, tufs_ctrl and tufs_dp.
`timescale 1ns / 1ps

module triangle_union_find_segmenter_core #(
  parameter int MAX_VERTICES = tufs_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tufs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tufs_pkg::out_item_t out_item
);
  import tufs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tufs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tufs_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> design/tufs_checker.sv
// port-level checks for the segmenter top level, with the bind that
// attaches them; uses tufs_pkg
`timescale 1ns / 1ps

module tufs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tufs_pkg::out_item_t out_item
);
  import tufs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one in work");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.error_flag |-> out_item.segment_count == '0 &&
      !out_item.vertex_seen && out_item.segment_id == '0)
    else $error("error item carries data");

  a_unseen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.vertex_seen |-> out_item.segment_id == '0)
    else $error("segment id without seen vertex");

endmodule

bind triangle_union_find_segmenter_core tufs_checker u_tufs_checker (.*);
